@@ sv/istc_pkg.sv @@
package istc_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 6;

  localparam logic [1:0] OP_QUERY      = 2'd0;
  localparam logic [1:0] OP_INSERT     = 2'd1;
  localparam logic [1:0] OP_REMOVE     = 2'd2;
  localparam logic [1:0] OP_REMOVE_ODD = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [VAL_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic                 success;
    logic                 full_res;
    logic [OUT_CNT_W-1:0] removed_count;
    logic [OUT_CNT_W-1:0] set_size;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic rd_last;
    logic append;
    logic move;
    logic load_out;
    logic res_success;
    logic res_full;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       exhausted;
    logic       full;
    logic       any_removed;
  } ctl_sts_t;

endpackage

@@ sv/integer_set_table_core.sv @@
// Set of distinct signed 32-bit values held in a table of CAPACITY entries with one read
// port and one write port. One beat in gives one beat out: query, insert (refused with
// full_res when the table is at capacity), remove (last entry moves into the freed slot)
// and remove-odd. The table memory is scanned one entry per cycle through its one read
// port, pausing while remove-odd moves the last entry into a freed slot. Items are taken
// one at a time, the next from the cycle after the previous result is loaded; the output
// register lets the next item enter while a result waits.
module integer_set_table_core #(
  parameter int CAPACITY = istc_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  istc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output istc_pkg::out_beat_t out_data
);

  istc_pkg::ctl_cmd_t cmd;
  istc_pkg::ctl_sts_t sts;

  istc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  istc_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ sv/istc_dpath.sv @@
module istc_dpath #(
  parameter int CAPACITY = istc_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  istc_pkg::in_beat_t  in_data,
  input  istc_pkg::ctl_cmd_t  cmd,
  output istc_pkg::ctl_sts_t  sts,
  output istc_pkg::out_beat_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [istc_pkg::VAL_W-1:0] mem [CAPACITY];

  logic [1:0]                 op_r;
  logic [istc_pkg::VAL_W-1:0] value_r;
  logic [istc_pkg::VAL_W-1:0] rdata_r;
  logic [CNT_W-1:0]           idx_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           removed_r;
  logic                       pend_r;
  logic [IDX_W-1:0]           pend_idx_r;
  istc_pkg::out_beat_t        out_r;

  logic                       scan_go;
  logic [IDX_W-1:0]           last_idx;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [istc_pkg::VAL_W-1:0] wr_data;
  logic                       match;

  assign scan_go  = cmd.scan && (idx_r < count_r);
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign rd_en    = scan_go || cmd.rd_last;
  assign rd_addr  = cmd.rd_last ? last_idx : idx_r[IDX_W-1:0];
  assign wr_en    = cmd.append || cmd.move;
  assign wr_addr  = cmd.append ? count_r[IDX_W-1:0] : pend_idx_r;
  assign wr_data  = cmd.append ? value_r : rdata_r;
  assign match    = (op_r == istc_pkg::OP_REMOVE_ODD) ? rdata_r[0] : (rdata_r == value_r);

  assign sts.op          = op_r;
  assign sts.hit         = pend_r && match;
  assign sts.exhausted   = !pend_r && (idx_r >= count_r);
  assign sts.full        = (count_r == CAP_C);
  assign sts.any_removed = (removed_r != '0);

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= scan_go;
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.move) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r      <= in_data.operation;
      value_r   <= in_data.item_value;
      idx_r     <= '0;
      removed_r <= '0;
    end else begin
      if (scan_go) begin
        idx_r      <= idx_r + CNT_W'(1);
        pend_idx_r <= idx_r[IDX_W-1:0];
      end
      if (cmd.move) begin
        idx_r     <= CNT_W'(pend_idx_r);
        removed_r <= removed_r + CNT_W'(1);
      end
    end
    if (cmd.load_out) begin
      out_r.success       <= cmd.res_success;
      out_r.full_res      <= cmd.res_full;
      out_r.removed_count <= istc_pkg::OUT_CNT_W'(removed_r);
      out_r.set_size      <= istc_pkg::OUT_CNT_W'(count_r);
    end
  end

endmodule

@@ sv/istc_ctrl.sv @@
module istc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  istc_pkg::ctl_sts_t sts,
  output istc_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_MOVE_RD = 3'd2;
  localparam logic [2:0] S_MOVE_WR = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       succ_r, succ_nxt;
  logic       full_r, full_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    succ_nxt  = succ_r;
    full_nxt  = full_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          succ_nxt  = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          unique case (sts.op)
            istc_pkg::OP_QUERY: begin
              succ_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
            istc_pkg::OP_INSERT: begin
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_MOVE_RD;
            end
          endcase
        end else if (sts.exhausted) begin
          state_nxt = S_FIN;
          if (sts.op == istc_pkg::OP_INSERT) begin
            if (sts.full) begin
              full_nxt = 1'b1;
            end else begin
              cmd.append = 1'b1;
              succ_nxt   = 1'b1;
            end
          end else if (sts.op == istc_pkg::OP_REMOVE_ODD) begin
            succ_nxt = sts.any_removed;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move = 1'b1;
        if (sts.op == istc_pkg::OP_REMOVE) begin
          succ_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out    = 1'b1;
          cmd.res_success = succ_r;
          cmd.res_full    = full_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    succ_r <= succ_nxt;
    full_r <= full_nxt;
  end

endmodule

@@ sv/istc_checker.sv @@
module istc_checker #(
  parameter int CAPACITY = istc_pkg::CAPACITY_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input istc_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat accepted while previous item in progress");

  a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 63) || (int'(out_data.set_size) <= CAPACITY))
    else $error("set size above capacity");

  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_res |->
      !out_data.success && (out_data.removed_count == '0) &&
      ((CAPACITY > 63) || (int'(out_data.set_size) == CAPACITY)))
    else $error("refused insert with inconsistent result");

endmodule

bind integer_set_table_core istc_checker #(
  .CAPACITY (CAPACITY)
) u_istc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
